FILE: src/lkvc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LRU key-value cache.
// Used by lkvc_store and lru_key_value_cache_top; depends on nothing.
package lkvc_pkg;

	// Width of the capacity register and its value after reset.
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

	// Default number of entries in the store.
	localparam int DEFAULT_ENTRIES = 16;

	// Field widths of keys and values.
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;

	// Access codes.
	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	// One access request.
	typedef struct packed {
		op_t                     op;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} req_t;

	// One access result.
	typedef struct packed {
		logic                    hit;
		logic signed [VAL_W-1:0] read_value;
		logic                    evicted;
		logic signed [KEY_W-1:0] evicted_key;
	} rsp_t;

endpackage

FILE: src/lru_key_value_cache_top.sv
`timescale 1ns / 1ps
// Top level of the LRU key-value cache: request register, result register,
// capacity register and the entry store. Depends on lkvc_pkg and lkvc_store.
//
// Usage:
//   Requests enter on in_valid with op, lookup_key and write_value; a request
//   is taken at a clock edge where in_valid is high and in_stall is low.
//   A get returns the stored value on a hit and refreshes the entry; a put
//   updates or inserts the key and may evict the least recent entry.
//   Results leave on out_valid with hit, read_value, evicted and evicted_key;
//   the receiver holds a result with out_stall.
//   A request is held in the request register and its result in the result
//   register. Throughput: one request per cycle while out_stall is low. The lookup
//   is combinational between the two registers; the store updates as the result is registered.
//   When the receiver stalls, the held result stays and one more request is
//   held in the request register; in_stall then rises until the result goes.
//   The capacity register is written on cfg_valid with cfg_ready, which is
//   always high; write it only while no request is in flight.
//   Reset empties the store and sets the capacity to sixteen; no clearing
//   pass is needed, so requests are taken from the first cycle after reset.
module lru_key_value_cache_top #(
	parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Capacity register write port.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lkvc_pkg::CAP_W-1:0]        cfg_capacity,
	// Request channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              op,
	input  logic signed [lkvc_pkg::KEY_W-1:0] lookup_key,
	input  logic signed [lkvc_pkg::VAL_W-1:0] write_value,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic signed [lkvc_pkg::VAL_W-1:0] read_value,
	output logic                              evicted,
	output logic signed [lkvc_pkg::KEY_W-1:0] evicted_key
);
	import lkvc_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic             valid_s1;
	req_t             req_s1;
	logic             out_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_next;
	logic             advance;
	logic             in_take;
	logic             step;

	// Handshake: the request register moves on when the result register is empty or its result is taken.
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;
	assign step      = valid_s1 && advance;
	assign cfg_ready = 1'b1;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_capacity;
		end
	end

	// Request register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Request register payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1.op    <= op_t'(op);
			req_s1.key   <= lookup_key;
			req_s1.value <= write_value;
		end
	end

	// Entry store: lookup and update for the request in the request register.
	lkvc_store #(
		.ENTRIES (ENTRIES)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (capacity_q),
		.step     (step),
		.req      (req_s1),
		.rsp      (rsp_next)
	);

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (step) begin
			rsp_q <= rsp_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = rsp_q.hit;
	assign read_value  = rsp_q.read_value;
	assign evicted     = rsp_q.evicted;
	assign evicted_key = rsp_q.evicted_key;

endmodule

FILE: src/lkvc_store.sv
`timescale 1ns / 1ps
// Entry storage of the LRU key-value cache with parallel key match, rank-based
// age tracking, the combinational lookup and the update, insert and evict logic.
// Depends on lkvc_pkg.
module lkvc_store #(
	parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lkvc_pkg::CAP_W-1:0]  capacity,
	input  logic                        step,
	input  lkvc_pkg::req_t              req,
	output lkvc_pkg::rsp_t              rsp
);
	import lkvc_pkg::*;

	localparam int AGE_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Entry state. Keys and values need no reset: they are only read when valid.
	logic signed [KEY_W-1:0] key_q   [ENTRIES];
	logic signed [VAL_W-1:0] value_q [ENTRIES];
	logic [ENTRIES-1:0]      valid_q;
	logic [AGE_W-1:0]        age_q   [ENTRIES];
	logic [CNT_W-1:0]        count_q;

	logic [ENTRIES-1:0]      match_vec;
	logic [ENTRIES-1:0]      oldest_vec;
	logic [ENTRIES-1:0]      free_vec;
	logic [ENTRIES-1:0]      first_free_vec;
	logic [ENTRIES-1:0]      new_slot_vec;
	logic                    hit_any;
	logic [AGE_W-1:0]        hit_age;
	logic signed [VAL_W-1:0] hit_value;
	logic signed [KEY_W-1:0] oldest_key;
	logic [AGE_W-1:0]        last_rank;
	logic [CMP_W-1:0]        cap_raw;
	logic [CMP_W-1:0]        cap_eff;
	logic                    is_full;
	logic                    is_put;
	logic                    do_evict;
	logic                    do_insert;

	// Parallel key match and the least recent entry, which holds the highest rank.
	always_comb begin
		last_rank = AGE_W'(count_q - CNT_W'(1));
		hit_age    = '0;
		hit_value  = '0;
		oldest_key = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i]  = valid_q[i] && (key_q[i] == req.key);
			oldest_vec[i] = valid_q[i] && (age_q[i] == last_rank);
			if (match_vec[i]) begin
				hit_age   = hit_age | age_q[i];
				hit_value = hit_value | value_q[i];
			end
			if (oldest_vec[i]) begin
				oldest_key = oldest_key | key_q[i];
			end
		end
		hit_any = |match_vec;
	end

	// Effective capacity: zero acts as one, values above the entry count saturate.
	always_comb begin
		cap_raw = CMP_W'(capacity);
		if (cap_raw == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_raw > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end else begin
			cap_eff = cap_raw;
		end
		is_full   = CMP_W'(count_q) >= cap_eff;
		is_put    = (req.op == OP_PUT);
		do_insert = is_put && !hit_any;
		do_evict  = do_insert && is_full && (count_q != '0);
	end

	// Slot for a new key: the evicted slot, else the lowest free slot.
	always_comb begin
		free_vec       = ~valid_q;
		first_free_vec = free_vec & (~free_vec + ENTRIES'(1));
		new_slot_vec   = do_evict ? oldest_vec : first_free_vec;
	end

	// Result of this access.
	always_comb begin
		rsp.hit         = hit_any;
		rsp.read_value  = (hit_any && !is_put) ? hit_value : '0;
		rsp.evicted     = do_evict;
		rsp.evicted_key = do_evict ? oldest_key : '0;
	end

	// Valid bits, ranks and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else if (step) begin
			if (hit_any) begin
				// Touched entry moves to the front, the more recent ones shift back.
				for (int i = 0; i < ENTRIES; i++) begin
					if (match_vec[i]) begin
						age_q[i] <= '0;
					end else if (valid_q[i] && (age_q[i] < hit_age)) begin
						age_q[i] <= age_q[i] + AGE_W'(1);
					end
				end
			end else if (do_insert) begin
				// New entry is most recent, every surviving entry ages by one.
				for (int i = 0; i < ENTRIES; i++) begin
					if (new_slot_vec[i]) begin
						valid_q[i] <= 1'b1;
						age_q[i]   <= '0;
					end else if (valid_q[i]) begin
						age_q[i] <= age_q[i] + AGE_W'(1);
					end
				end
				if (!do_evict) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// Key and value payload.
	always_ff @(posedge clk) begin
		if (step && is_put) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (hit_any ? match_vec[i] : new_slot_vec[i]) begin
					value_q[i] <= req.value;
				end
				if (!hit_any && new_slot_vec[i]) begin
					key_q[i] <= req.key;
				end
			end
		end
	end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache_top: drives get and put requests,
// predicts each result with an LRU store of its own and compares field by field.
// Depends on lkvc_pkg and the RTL of lru_key_value_cache_top only.
module testbench;
	import lkvc_pkg::*;

	localparam int ENTRIES = DEFAULT_ENTRIES;
	localparam int MAX_REPORTS = 10;

	// Clock and reset.
	logic clk = 1'b0;
	logic arst_n;

	// Capacity write port.
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_capacity;

	// Request channel.
	logic                    in_valid;
	logic                    in_stall;
	logic                    op;
	logic signed [KEY_W-1:0] lookup_key;
	logic signed [VAL_W-1:0] write_value;

	// Result channel.
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    hit;
	logic signed [VAL_W-1:0] read_value;
	logic                    evicted;
	logic signed [KEY_W-1:0] evicted_key;

	// Predicted store contents, with rank 0 as most recent.
	logic [KEY_W-1:0] slot_key [ENTRIES];
	logic [VAL_W-1:0] slot_val [ENTRIES];
	bit               slot_used [ENTRIES];
	int               slot_rank [ENTRIES];
	int               used_count;
	logic [CAP_W-1:0] model_capacity;

	// Results predicted for accepted requests, oldest first.
	rsp_t results_due[$];

	// Run bookkeeping.
	int  mismatches = 0;
	int  requests_sent = 0;
	int  gets_sent = 0;
	int  puts_sent = 0;
	int  results_seen = 0;
	int  hits_seen = 0;
	int  evictions_seen = 0;
	int  capacity_writes = 0;
	int  hold_cycles = 0;
	bit  throttle = 1'b1;

	lru_key_value_cache_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_capacity (cfg_capacity),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.lookup_key   (lookup_key),
		.write_value  (write_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.read_value   (read_value),
		.evicted      (evicted),
		.evicted_key  (evicted_key)
	);

	always #6 clk = ~clk;

	// Counts a failure and reports only the first few.
	function automatic void flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("MISMATCH at %0t ns: %s", $realtime, msg);
		end
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			flag_mismatch($sformatf("%s expected %h, got %h", field, want, got));
		end
	endfunction

	// Empty store and reset capacity, as after arst_n.
	function automatic void clear_store();
		for (int i = 0; i < ENTRIES; i++) begin
			slot_key[i] = '0;
			slot_val[i] = '0;
			slot_used[i] = 1'b0;
			slot_rank[i] = 0;
		end
		used_count = 0;
		model_capacity = CAPACITY_RESET;
	endfunction

	// Applies one access to the predicted store and returns its result.
	function automatic rsp_t lru_predict(req_t r);
		rsp_t res;
		int limit;
		int slot;
		int oldest;
		int free_slot;
		int old_rank;
		res = '0;
		limit = (model_capacity == 0) ? 1 : int'(model_capacity);
		if (limit > ENTRIES) begin
			limit = ENTRIES;
		end
		slot = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot < 0 && slot_used[i] && slot_key[i] == r.key) begin
				slot = i;
			end
		end
		if (slot >= 0) begin
			// Hit: read or overwrite, then promote to most recent.
			res.hit = 1'b1;
			if (r.op == OP_GET) begin
				res.read_value = slot_val[slot];
			end else begin
				slot_val[slot] = r.value;
			end
			old_rank = slot_rank[slot];
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot_used[i] && slot_rank[i] < old_rank) begin
					slot_rank[i]++;
				end
			end
			slot_rank[slot] = 0;
		end else if (r.op == OP_PUT) begin
			// Full store: drop the least recent entry first.
			if (used_count >= limit) begin
				oldest = -1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_used[i] && (oldest < 0 || slot_rank[i] > slot_rank[oldest])) begin
						oldest = i;
					end
				end
				if (oldest >= 0) begin
					res.evicted = 1'b1;
					res.evicted_key = slot_key[oldest];
					slot_used[oldest] = 1'b0;
					slot_rank[oldest] = 0;
					used_count--;
				end
			end
			// Insert the new key as most recent.
			free_slot = -1;
			for (int i = 0; i < ENTRIES; i++) begin
				if (free_slot < 0 && !slot_used[i]) begin
					free_slot = i;
				end
			end
			if (free_slot >= 0) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_used[i]) begin
						slot_rank[i]++;
					end
				end
				slot_key[free_slot] = r.key;
				slot_val[free_slot] = r.value;
				slot_used[free_slot] = 1'b1;
				slot_rank[free_slot] = 0;
				used_count++;
			end
		end
		return res;
	endfunction

	// Sends one request after a random gap and records its predicted result.
	// Called at a rising edge; returns at the edge where the request is taken.
	task automatic send_request(input op_t kind, input logic [31:0] key, input logic [31:0] value);
		req_t r;
		int gap;
		r.op = kind;
		r.key = key;
		r.value = value;
		gap = throttle ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= r.op;
		lookup_key <= r.key;
		write_value <= r.value;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		results_due.push_back(lru_predict(r));
		requests_sent++;
		if (kind == OP_GET) begin
			gets_sent++;
		end else begin
			puts_sent++;
		end
	endtask

	// Stops sending and waits until every predicted result has been seen.
	task automatic drain_results();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (results_due.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		if (results_due.size() != 0) begin
			flag_mismatch($sformatf("%0d results never arrived", results_due.size()));
			results_due.delete();
		end
	endtask

	// Writes the capacity register while no request is in flight.
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		drain_results();
		cfg_capacity <= cap;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		model_capacity = cap;
		cfg_valid <= 1'b0;
		capacity_writes++;
	endtask

	// Receiver: holds off for a random number of cycles after each result.
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			hold_cycles = throttle ? $urandom_range(0, 7) : 0;
		end else if (hold_cycles > 0) begin
			hold_cycles--;
		end
		out_stall <= (hold_cycles > 0);
	end

	// Compares each accepted result with the oldest prediction.
	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (hit === 1'b1) begin
				hits_seen++;
			end
			if (evicted === 1'b1) begin
				evictions_seen++;
			end
			if (results_due.size() == 0) begin
				flag_mismatch($sformatf("result with nothing expected: hit %b value %h",
					hit, read_value));
			end else begin
				want = results_due.pop_front();
				check_field("hit", 32'(want.hit), 32'(hit));
				check_field("read_value", want.read_value, read_value);
				check_field("evicted", 32'(want.evicted), 32'(evicted));
				check_field("evicted_key", want.evicted_key, evicted_key);
			end
		end
	end

	// Empty store at reset capacity, then extreme keys and values.
	task automatic test_empty_and_extremes();
		send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_GET, 32'h7FFF_FFFF, 32'h5555_5555);
		send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(OP_GET, 32'h0000_0000, 32'hAAAA_AAAA);
		send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(OP_GET, 32'h7FFF_FFFE, 32'h0000_0000);
	endtask

	// A put on a present key overwrites the value in place.
	task automatic test_update_in_place();
		send_request(OP_PUT, 32'h8000_0000, 32'h1234_5678);
		send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
	endtask

	// Capacity lowered below the entry count: each new key evicts just one.
	task automatic test_shrunk_capacity();
		write_capacity(5'd1);
		send_request(OP_PUT, 32'h0000_0001, 32'hDEAD_BEEF);
		send_request(OP_PUT, 32'h0000_0002, 32'h0BAD_F00D);
		send_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
	endtask

	// Zero acts as one; values above the store size saturate.
	task automatic test_capacity_clamping();
		write_capacity(5'd0);
		send_request(OP_PUT, 32'h0000_0003, 32'h0000_0033);
		write_capacity(5'd31);
		send_request(OP_PUT, 32'h0000_0004, 32'h0000_0044);
		send_request(OP_PUT, 32'h0000_0005, 32'h0000_0055);
		write_capacity(5'd17);
		send_request(OP_PUT, 32'h0000_0006, 32'h0000_0066);
	endtask

	// Phases of mixed traffic over a small key set, each at its own capacity.
	task automatic test_random_traffic();
		logic [31:0] key_pool[$];
		logic [CAP_W-1:0] cap;
		logic [31:0] key;
		op_t kind;
		int pool_size;
		for (int phase = 0; phase < 16; phase++) begin
			case (phase)
				0: cap = 5'd31;
				1: cap = 5'd0;
				2: cap = 5'd1;
				3: cap = 5'd16;
				4: cap = 5'd17;
				5: cap = 5'd2;
				default: cap = CAP_W'($urandom_range(0, 31));
			endcase
			write_capacity(cap);
			throttle = (phase % 4) != 3;

			// Small key sets give hits; larger ones give evictions.
			pool_size = $urandom_range(2, 24);
			key_pool.delete();
			repeat (pool_size) key_pool.push_back($urandom);
			if (phase == 6) begin
				key_pool.push_back(32'h8000_0000);
				key_pool.push_back(32'h7FFF_FFFF);
				key_pool.push_back(32'h0000_0000);
				key_pool.push_back(32'hFFFF_FFFF);
			end

			repeat (100) begin
				kind = ($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET;
				if ($urandom_range(0, 15) == 0) begin
					key = $urandom;
				end else begin
					key = key_pool[$urandom_range(0, key_pool.size() - 1)];
				end
				send_request(kind, key, $urandom);
				if ($urandom_range(0, 63) == 0) begin
					drain_results();
				end
			end
		end
		throttle = 1'b1;
	endtask

	// Reset, directed tests, random traffic, then the verdict.
	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_capacity <= '0;
		in_valid <= 1'b0;
		op <= OP_GET;
		lookup_key <= '0;
		write_value <= '0;
		clear_store();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_and_extremes();
		test_update_in_place();
		drain_results();
		test_shrunk_capacity();
		test_capacity_clamping();
		test_random_traffic();

		drain_results();
		repeat (4) @(posedge clk);
		if (results_due.size() != 0) begin
			flag_mismatch($sformatf("%0d expected results left over", results_due.size()));
		end
		$display("Run covered %0d requests (%0d gets, %0d puts) over %0d capacity settings.",
			requests_sent, gets_sent, puts_sent, capacity_writes);
		$display("Checked %0d results: %0d hits, %0d evictions, %0d mismatches.",
			results_seen, hits_seen, evictions_seen, mismatches);
		if (mismatches == 0) begin
			$display("PASS lru_key_value_cache_top");
		end else begin
			$display("FAIL lru_key_value_cache_top");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5000000;
		$display("FAIL lru_key_value_cache_top");
		$finish;
	end

endmodule
